// File: hdl/usn_pkg.sv
package usn_pkg;

  // Work handed from the byte classifier to the output stage.
  typedef enum logic [1:0] {
    ACT_SEP  = 2'd0,
    ACT_CHAR = 2'd1,
    ACT_END  = 2'd2
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [6:0] ch;
  } q_entry_t;

  localparam int unsigned LenW = 12;
  localparam logic [LenW-1:0] MaxLenReset = 12'd511;

  localparam logic [6:0] CharSpace = 7'h20;

endpackage

// File: hdl/usn_front.sv
module usn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              push_o,
  output usn_pkg::q_entry_t push_data_o,
  input  logic              q_full_i
);

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ACCENT  = 3'd1,
    KIND_E2      = 3'd2,
    KIND_TM      = 3'd3,
    KIND_STAR    = 3'd4,
    KIND_SPARKLE = 3'd5,
    KIND_PLAIN   = 3'd6
  } kind_e;

  localparam logic [7:0] ByteC3   = 8'hC3;
  localparam logic [7:0] ByteE2   = 8'hE2;
  localparam logic [7:0] ByteF0   = 8'hF0;
  localparam logic [7:0] ByteTm1  = 8'h84;
  localparam logic [7:0] ByteTm2  = 8'hA2;
  localparam logic [7:0] ByteSt1  = 8'h98;
  localparam logic [7:0] ByteSt2  = 8'h85;
  localparam logic [7:0] ByteSp1  = 8'h9F;
  localparam logic [7:0] ByteSp2  = 8'h8C;

  kind_e      kind_q, kind_d;
  logic [1:0] swallow_q, swallow_d;
  logic       match_q, match_d;
  logic       accept;
  logic       push;
  usn_pkg::q_entry_t ent;

  function automatic logic [6:0] fold_accent(input logic [7:0] b);
    logic [6:0] r;
    case (b)
      8'hA1, 8'h81: r = 7'h61;
      8'hA9, 8'h89: r = 7'h65;
      8'hAD, 8'h8D: r = 7'h69;
      8'hB3, 8'h93: r = 7'h6F;
      8'hBA, 8'h9A: r = 7'h75;
      8'hB1, 8'h91: r = 7'h6E;
      default:      r = 7'h00;
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic       hit;
    logic [6:0] folded;
    kind_d    = kind_q;
    swallow_d = swallow_q;
    match_d   = match_q;
    push      = 1'b0;
    ent.act   = usn_pkg::ACT_SEP;
    ent.ch    = '0;
    hit       = 1'b0;
    folded    = fold_accent(in_byte_i);
    if (in_byte_i == 8'h00) begin
      push      = 1'b1;
      ent.act   = usn_pkg::ACT_END;
      kind_d    = KIND_NONE;
      swallow_d = 2'd0;
      match_d   = 1'b0;
    end else if (swallow_q != 2'd0) begin
      // Any nonzero byte after a lead byte counts as a continuation byte.
      if (kind_q == KIND_E2 && swallow_q == 2'd2) begin
        if (in_byte_i == ByteTm1) begin
          kind_d = KIND_TM;
        end else if (in_byte_i == ByteSt1) begin
          kind_d = KIND_STAR;
        end else begin
          match_d = 1'b0;
        end
      end else begin
        hit = (kind_q == KIND_TM && swallow_q == 2'd1 && in_byte_i == ByteTm2) ||
              (kind_q == KIND_STAR && swallow_q == 2'd1 && in_byte_i == ByteSt2) ||
              (kind_q == KIND_SPARKLE && swallow_q == 2'd2 && in_byte_i == ByteSp2) ||
              (kind_q == KIND_SPARKLE && swallow_q != 2'd2 && in_byte_i == ByteSp1);
        if (!hit) begin
          match_d = 1'b0;
        end
      end
      swallow_d = swallow_q - 2'd1;
      if (swallow_d == 2'd0) begin
        if (kind_q == KIND_ACCENT) begin
          push = 1'b1;
          if (folded != 7'h00) begin
            ent.act = usn_pkg::ACT_CHAR;
            ent.ch  = folded;
          end
        end else if (!((kind_q == KIND_E2 || kind_q == KIND_TM || kind_q == KIND_STAR ||
                        kind_q == KIND_SPARKLE) && match_d)) begin
          push = 1'b1;
        end
        kind_d  = KIND_NONE;
        match_d = 1'b0;
      end
    end else begin
      if (in_byte_i[7] == 1'b0) begin
        push = 1'b1;
        if ((in_byte_i >= 8'h30 && in_byte_i <= 8'h39) ||
            (in_byte_i >= 8'h61 && in_byte_i <= 8'h7A)) begin
          ent.act = usn_pkg::ACT_CHAR;
          ent.ch  = in_byte_i[6:0];
        end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h5A) begin
          ent.act = usn_pkg::ACT_CHAR;
          ent.ch  = in_byte_i[6:0] | 7'h20;
        end
      end else if (in_byte_i == ByteC3) begin
        kind_d = KIND_ACCENT; swallow_d = 2'd1; match_d = 1'b0;
      end else if (in_byte_i == ByteE2) begin
        kind_d = KIND_E2; swallow_d = 2'd2; match_d = 1'b1;
      end else if (in_byte_i == ByteF0) begin
        kind_d = KIND_SPARKLE; swallow_d = 2'd3; match_d = 1'b1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        kind_d = KIND_PLAIN; swallow_d = 2'd1; match_d = 1'b0;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        kind_d = KIND_PLAIN; swallow_d = 2'd2; match_d = 1'b0;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        kind_d = KIND_PLAIN; swallow_d = 2'd3; match_d = 1'b0;
      end else begin
        // Stray continuation bytes and 0xF8..0xFF act as a separator.
        push = 1'b1;
      end
    end
  end

  assign push_o      = accept && push;
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_NONE;
      swallow_q <= 2'd0;
      match_q   <= 1'b0;
    end else if (accept) begin
      kind_q    <= kind_d;
      swallow_q <= swallow_d;
      match_q   <= match_d;
    end
  end

endmodule

// File: hdl/usn_queue.sv
module usn_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  usn_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output usn_pkg::q_entry_t head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  usn_pkg::q_entry_t mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/usn_back.sv
module usn_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [usn_pkg::LenW-1:0]   max_len_i,
  input  logic                       q_valid_i,
  input  usn_pkg::q_entry_t          q_head_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [6:0]                 out_char_o,
  output logic                       char_valid_o,
  output logic                       text_done_o,
  output logic                       last_o
);

  localparam int unsigned LenW = usn_pkg::LenW;

  logic            out_valid_q, out_valid_d;
  logic [6:0]      out_char_q, out_char_d;
  logic            out_cv_q, out_cv_d;
  logic            out_done_q, out_done_d;
  logic            out_last_q, out_last_d;
  logic            second_q, second_d;
  logic [6:0]      ch_q, ch_d;
  logic            pend_q, pend_d;
  logic [LenW-1:0] count_q, count_d;
  logic            can_load;
  logic            pop;
  logic [LenW:0]   count_plus2;

  assign can_load    = !out_valid_q || out_ready_i;
  assign count_plus2 = {1'b0, count_q} + (LenW+1)'(2);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_cv_d    = out_cv_q;
    out_done_d  = out_done_q;
    out_last_d  = out_last_q;
    second_d    = second_q;
    ch_d        = ch_q;
    pend_d      = pend_q;
    count_d     = count_q;
    pop         = 1'b0;
    if (can_load) begin
      if (second_q) begin
        // Character that follows a released space.
        out_valid_d = 1'b1;
        out_char_d  = ch_q;
        out_cv_d    = 1'b1;
        out_done_d  = 1'b0;
        out_last_d  = 1'b1;
        second_d    = 1'b0;
      end else if (q_valid_i) begin
        pop = 1'b1;
        case (q_head_i.act)
          usn_pkg::ACT_SEP: begin
            if (count_q != '0 && !pend_q && count_q < max_len_i) begin
              pend_d = 1'b1;
            end
          end
          usn_pkg::ACT_END: begin
            out_valid_d = 1'b1;
            out_char_d  = '0;
            out_cv_d    = 1'b0;
            out_done_d  = 1'b1;
            out_last_d  = 1'b1;
            pend_d      = 1'b0;
            count_d     = '0;
          end
          usn_pkg::ACT_CHAR: begin
            if (pend_q) begin
              pend_d = 1'b0;
              if (count_plus2 <= {1'b0, max_len_i}) begin
                out_valid_d = 1'b1;
                out_char_d  = usn_pkg::CharSpace;
                out_cv_d    = 1'b1;
                out_done_d  = 1'b0;
                out_last_d  = 1'b0;
                second_d    = 1'b1;
                ch_d        = q_head_i.ch;
                count_d     = count_plus2[LenW-1:0];
              end else if (count_q < max_len_i) begin
                // No room for space plus character: both go and the string is full.
                count_d = max_len_i;
              end
            end else if (count_q < max_len_i) begin
              out_valid_d = 1'b1;
              out_char_d  = q_head_i.ch;
              out_cv_d    = 1'b1;
              out_done_d  = 1'b0;
              out_last_d  = 1'b1;
              count_d     = count_q + 1'b1;
            end
          end
          default: begin
            pop = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_cv_q   <= out_cv_d;
    out_done_q <= out_done_d;
    out_last_q <= out_last_d;
    ch_q       <= ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
      pend_q      <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
    end
  end

  assign q_pop_o      = pop;
  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign char_valid_o = out_cv_q;
  assign text_done_o  = out_done_q;
  assign last_o       = out_last_q;

endmodule

// File: hdl/utf8_search_text_normalizer_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] = in_byte
// m_axis    out        tdata[6:0] = out_char, tuser = {text_done, char_valid}, tlast = last_of_item
// cfg       in         cfg_wdata_i[11:0] = max_out_length (write on cfg_we_i)
//
// One byte is taken per cycle while the queue has room; results leave from a registered output stage.
// A byte that releases a held space gives two results, the space and then the character, so the output
// stage stays busy with that item while the queue keeps absorbing input.
// Reset clears the sequence state, the queue, the held space, the character count, and loads
// a length limit of 511. Each side stalls on its own across the QueueDepth-entry queue.
module utf8_search_text_normalizer_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic [1:0]  m_axis_tuser,   // [0] char_valid, [1] text_done
  output logic        m_axis_tlast,   // last_of_item
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i     // [11:0] max_out_length
);

  logic [usn_pkg::LenW-1:0] max_len_q;
  logic                     push, full, q_valid, pop;
  usn_pkg::q_entry_t        push_data, head;
  logic [6:0]               out_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= usn_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  usn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (full)
  );

  usn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  usn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_len_i    (max_len_q),
    .q_valid_i    (q_valid),
    .q_head_i     (head),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .char_valid_o (m_axis_tuser[0]),
    .text_done_o  (m_axis_tuser[1]),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
